FILE: rtl/tftt_pkg.sv
`timescale 1ns / 1ps
package tftt_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [3:0] STATE_TIME_WAIT = 4'd6;
  localparam logic [3:0] STATE_CLOSE = 4'd7;
  localparam logic REQ_STATE = 1'b0;
  localparam logic REQ_RETRANS = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] cg_key;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] addr_family;
    logic [15:0] protocol_num;
    logic [3:0]  old_state;
    logic [3:0]  new_state;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_cgroup;
    logic [63:0] out_time;
    logic [31:0] out_src_addr;
    logic [31:0] out_dst_addr;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] out_family;
    logic [3:0]  out_old_state;
    logic [3:0]  out_new_state;
    logic [31:0] flow_retrans_count;
    logic [63:0] flow_first_time;
    logic        not_tracked;
  } out_item_t;

  // One table row; addresses src high / dst low, ports likewise
  typedef struct packed {
    logic        valid;
    logic [63:0] cgroup;
    logic [63:0] addresses;
    logic [31:0] ports;
    logic [3:0]  tcp_state;
    logic [31:0] retrans;
    logic [63:0] first_seen;
    logic [63:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_end;
    logic scan_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

FILE: rtl/tftt_req_if.sv
`timescale 1ns / 1ps
interface tftt_req_if;
  logic valid;
  logic ready;
  tftt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tftt_evt_if.sv
`timescale 1ns / 1ps
interface tftt_evt_if;
  logic valid;
  logic ready;
  tftt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tftt_ctrl.sv
`timescale 1ns / 1ps
module tftt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tftt_pkg::ctl_sts_t  sts,
  output tftt_pkg::ctl_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing: clear pass, accept, scan, write back
  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.cnt_end) begin
          cmd.clear = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/tftt_datapath.sv
`timescale 1ns / 1ps
module tftt_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  tftt_pkg::in_item_t    req_data,
  input  tftt_pkg::ctl_cmd_t    cmd,
  output tftt_pkg::ctl_sts_t    sts,
  output logic                  evt_valid,
  input  logic                  evt_ready,
  output tftt_pkg::out_item_t   evt_data
);

  localparam int IW = tftt_pkg::IDX_W;
  localparam logic [IW:0] DEPTH = (IW + 1)'(tftt_pkg::TABLE_ENTRIES);

  tftt_pkg::entry_t mem [tftt_pkg::TABLE_ENTRIES];
  tftt_pkg::entry_t rdata;
  tftt_pkg::in_item_t it;

  logic [IW:0]   cnt;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  tftt_pkg::entry_t hit_word;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic          we;
  logic [IW-1:0] waddr;
  tftt_pkg::entry_t wdata;
  logic          emit;
  tftt_pkg::out_item_t evt_next;
  tftt_pkg::entry_t nw;
  tftt_pkg::entry_t tgt;
  logic          key_eq;
  logic          closing;

  assign key_eq = rdata.valid && rdata.cgroup == it.cg_key &&
                  rdata.addresses == {it.src_addr, it.dst_addr} &&
                  rdata.ports == {it.src_port, it.dst_port};

  assign sts.cnt_end = (cnt == DEPTH);
  assign sts.scan_done = hit || ((cnt == DEPTH) && !pend);
  assign sts.out_busy = evt_valid;

  // Memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.scan && cnt != DEPTH) begin
      rdata <= mem[cnt[IW-1:0]];
    end
  end

  // Scan counter and lookup tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pend <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.clear) begin
      cnt <= cnt + (IW + 1)'(1);
    end else if (cmd.load) begin
      cnt <= '0;
      pend <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (cnt != DEPTH) begin
        cnt <= cnt + (IW + 1)'(1);
        pend <= 1'b1;
        pend_idx <= cnt[IW-1:0];
      end else begin
        pend <= 1'b0;
      end
      if (pend && !hit) begin
        if (key_eq) begin
          hit <= 1'b1;
          hit_idx <= pend_idx;
          hit_word <= rdata;
        end else if (!rdata.valid && !free_found) begin
          free_found <= 1'b1;
          free_idx <= pend_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= req_data;
    end
  end

  // Write-back and event formation
  always_comb begin
    closing = (it.new_state == tftt_pkg::STATE_CLOSE) ||
              (it.new_state == tftt_pkg::STATE_TIME_WAIT);
    nw.valid = 1'b1;
    nw.cgroup = it.cg_key;
    nw.addresses = {it.src_addr, it.dst_addr};
    nw.ports = {it.src_port, it.dst_port};
    nw.tcp_state = it.new_state;
    nw.retrans = '0;
    nw.first_seen = it.timestamp;
    nw.last_seen = it.timestamp;
    tgt = hit ? hit_word : nw;
    we = 1'b0;
    waddr = hit ? hit_idx : free_idx;
    wdata = tgt;
    emit = 1'b0;
    if (cmd.clear) begin
      we = 1'b1;
      waddr = cnt[IW-1:0];
      wdata = '0;
    end else if (cmd.commit) begin
      if (it.req_type == tftt_pkg::REQ_RETRANS) begin
        we = hit || free_found;
        if (hit) begin
          wdata.retrans = hit_word.retrans + 32'd1;
        end else begin
          wdata.retrans = 32'd1;
          wdata.first_seen = '0;
          wdata.last_seen = '0;
        end
      end else if (it.protocol_num == tftt_pkg::PROTO_TCP) begin
        emit = 1'b1;
        we = hit || free_found;
        wdata.tcp_state = it.new_state;
        wdata.last_seen = it.timestamp;
        wdata.valid = !closing;
      end
    end
    evt_next.out_cgroup = it.cg_key;
    evt_next.out_time = it.timestamp;
    evt_next.out_src_addr = it.src_addr;
    evt_next.out_dst_addr = it.dst_addr;
    evt_next.out_src_port = it.src_port;
    evt_next.out_dst_port = it.dst_port;
    evt_next.out_family = it.addr_family;
    evt_next.out_old_state = it.old_state;
    evt_next.out_new_state = it.new_state;
    evt_next.flow_retrans_count = (hit || free_found) ? tgt.retrans : 32'd0;
    evt_next.flow_first_time = (hit || free_found) ? tgt.first_seen : 64'd0;
    evt_next.not_tracked = !(hit || free_found);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (emit) begin
      evt_valid <= 1'b1;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt_data <= evt_next;
    end
  end

endmodule

FILE: rtl/tcp_flow_tracking_table_core.sv
`timescale 1ns / 1ps
// TCP flow tracking table: keeps up to TABLE_ENTRIES flows keyed by cgroup,
// IPv4 addresses and ports in one table memory with one read and one write
// port. After reset a clearing pass over every table entry runs before
// the first request is taken. Each request scans the table one entry per cycle
// through the registered read port. The scan stops at the entry that holds a
// matching flow and otherwise covers every entry, for a new flow or a full
// table. A write-back follows the scan and waits for as long as the previous
// event has not been taken. A TCP state change yields one event transfer;
// retransmits and non-TCP state changes yield none. The event register lets
// the next request start while an event waits to be taken.
module tcp_flow_tracking_table_core (
  input logic clk,
  input logic rst,
  tftt_req_if.sink   req_ch,
  tftt_evt_if.source evt_ch
);

  tftt_pkg::ctl_cmd_t cmd;
  tftt_pkg::ctl_sts_t sts;

  tftt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tftt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .evt_valid (evt_ch.valid),
    .evt_ready (evt_ch.ready),
    .evt_data  (evt_ch.data)
  );

endmodule
